### rtl/cls_pkg.sv
// Shared constants and types for the circular list store.
// Field widths, operation and status codes, default capacity.
// No dependencies.
package cls_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W      = 2;
  localparam int DATA_W    = 32;
  localparam int OFFSET_W  = 31;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int DIV_CNT_W = $clog2(OFFSET_W);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

### rtl/circular_list_store.sv
// Circular list store: a bounded ring of signed 32-bit values with a head
// index and an element count. Push front, push back and pop front, as well
// as any request on an empty store, go from S_IDLE straight to S_FIN, which
// loads their response into the output register once the output slot is
// free; the block then returns to S_IDLE to take the next request. A read at
// an offset passes through S_DIV, S_READ and S_FIN. In S_DIV the offset is
// reduced modulo the live count by a bit-serial restoring remainder, one
// offset bit per cycle over all 31 bits. This is followed by one registered
// ring read in S_READ and the response load in S_FIN. One request is in
// flight at a time; a new request is taken once the previous response sits
// in the output register, and a stalled output holds the block until it is
// taken.
// Depends on cls_pkg.
module circular_list_store #(
  parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cls_pkg::OP_W-1:0]          op,
  input  logic signed [cls_pkg::DATA_W-1:0] value,
  input  logic [cls_pkg::OFFSET_W-1:0]      offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cls_pkg::DATA_W-1:0] read_value,
  output logic [cls_pkg::STATUS_W-1:0]      status,
  output logic [cls_pkg::COUNT_W-1:0]       count
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CEXTW = (CW > cls_pkg::COUNT_W) ? CW : cls_pkg::COUNT_W;
  localparam logic [IW:0]   CAP_SUM = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);
  localparam logic [cls_pkg::DIV_CNT_W-1:0] LAST_BIT =
    cls_pkg::DIV_CNT_W'(cls_pkg::OFFSET_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_FIN
  } state_t;

  state_t                              state;
  logic [cls_pkg::OP_W-1:0]            op_q;
  logic [cls_pkg::DATA_W-1:0]          value_q;
  logic [cls_pkg::OFFSET_W-1:0]        off_sr;
  logic [cls_pkg::DIV_CNT_W-1:0]       bit_cnt;
  logic [CW-1:0]                       rem;
  logic [IW-1:0]                       head;
  logic [CW-1:0]                       elems;
  logic [cls_pkg::DATA_W-1:0]          rd_data;
  logic [cls_pkg::DATA_W-1:0]          ring [CAPACITY];

  logic                                in_fire;
  logic                                out_free;
  logic                                is_empty;
  logic                                is_full;
  logic [CW:0]                         rem_shift;
  logic [CW-1:0]                       rem_next;
  logic [IW-1:0]                       rd_addr;
  logic [IW-1:0]                       head_next;
  logic [CW-1:0]                       elems_next;
  logic [CEXTW-1:0]                    elems_ext;
  cls_pkg::status_t                    status_next;
  logic [cls_pkg::DATA_W-1:0]          rd_next;
  logic                                wr_en;
  logic [IW-1:0]                       wr_addr;

  // a + b with both below CAPACITY, wrapped round the ring
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CAP_SUM) begin
      sum = sum - CAP_SUM;
    end
    return sum[IW-1:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign is_empty = (elems == '0);
  assign is_full  = (elems == CAP_CNT);

  // restoring remainder step, offset MSB first
  always_comb begin
    rem_shift = {rem, off_sr[cls_pkg::OFFSET_W-1]};
    if (rem_shift >= {1'b0, elems}) begin
      rem_next = CW'(rem_shift - {1'b0, elems});
    end else begin
      rem_next = rem_shift[CW-1:0];
    end
  end

  assign rd_addr = wrap_add(head, rem[IW-1:0]);

  always_comb begin
    head_next   = head;
    elems_next  = elems;
    status_next = cls_pkg::ST_OK;
    rd_next     = '0;
    wr_en       = 1'b0;
    wr_addr     = head;
    case (cls_pkg::op_t'(op_q))
      cls_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = cls_pkg::ST_FULL;
        end else begin
          head_next  = (head == '0) ? LAST_IX : head - 1'b1;
          wr_addr    = head_next;
          wr_en      = 1'b1;
          elems_next = elems + 1'b1;
        end
      end
      cls_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = cls_pkg::ST_FULL;
        end else begin
          wr_addr    = wrap_add(head, elems[IW-1:0]);
          wr_en      = 1'b1;
          elems_next = elems + 1'b1;
        end
      end
      cls_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = cls_pkg::ST_EMPTY;
        end else begin
          head_next  = (head == LAST_IX) ? '0 : head + 1'b1;
          elems_next = elems - 1'b1;
        end
      end
      default: begin
        if (is_empty) begin
          status_next = cls_pkg::ST_EMPTY;
        end else begin
          rd_next = rd_data;
        end
      end
    endcase
  end

  assign elems_ext = CEXTW'(elems_next);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= ring[rd_addr];
    end
    if (state == S_FIN && out_free && wr_en) begin
      ring[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      elems     <= '0;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
      rem       <= '0;
    end else begin
      // a response loaded in S_FIN takes over the slot being drained
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_q    <= op;
            value_q <= value;
            off_sr  <= offset;
            bit_cnt <= '0;
            rem     <= '0;
            if (cls_pkg::op_t'(op) == cls_pkg::OP_READ && !is_empty) begin
              state <= S_DIV;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          off_sr  <= {off_sr[cls_pkg::OFFSET_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == LAST_BIT) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            head       <= head_next;
            elems      <= elems_next;
            read_value <= rd_next;
            status     <= status_next;
            count      <= elems_ext[cls_pkg::COUNT_W-1:0];
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/cls_checker.sv
// Port-level checks for circular_list_store, bound to the top level.
// Depends on cls_pkg.
module cls_checker #(
  parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cls_pkg::DATA_W-1:0] read_value,
  input logic [cls_pkg::STATUS_W-1:0]      status,
  input logic [cls_pkg::COUNT_W-1:0]       count
);

  localparam int CEXTW = ($clog2(CAPACITY + 1) > cls_pkg::COUNT_W) ?
                         $clog2(CAPACITY + 1) : cls_pkg::COUNT_W;
  localparam logic [CEXTW-1:0] CAP_EXT = CEXTW'(CAPACITY);
  localparam logic [cls_pkg::COUNT_W-1:0] CAP_COUNT = CAP_EXT[cls_pkg::COUNT_W-1:0];

  // a held response keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(read_value) && $stable(status) && $stable(count))
    else $error("response changed while stalled");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cls_pkg::ST_OK |-> read_value == '0)
    else $error("failed request returned data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cls_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cls_pkg::ST_FULL |-> count == CAP_COUNT)
    else $error("full status without full count");

endmodule

bind circular_list_store cls_checker #(.CAPACITY(CAPACITY)) u_cls_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_value (read_value),
  .status     (status),
  .count      (count)
);
